[rtl/ffvu_pkg.sv]
// Shared types, widths and register codes of the face flux volume update unit.
`default_nettype none
package ffvu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int TS_W      = 31;
  localparam int VOL_W     = 31;
  localparam int QUOT_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;

  // three products of 32x32 summed exactly
  localparam int SUM_W     = PROD_W + 2;
  localparam int DOT_W     = SUM_W - FRAC_BITS;
  localparam int DMAG_W    = PROD_W - FRAC_BITS;
  localparam int DMAG_HI_W = DMAG_W - DATA_W;
  localparam int P1_W      = DMAG_W + DATA_W;
  localparam int P1_HI_W   = P1_W - PROD_W;
  localparam int NUMF_W    = P1_W + TS_W;
  localparam int NUM_W     = NUMF_W - FRAC_BITS;
  localparam int NUM_HI_W  = NUM_W - QUOT_W;
  localparam int CMP_W     = (NUM_HI_W > VOL_W) ? NUM_HI_W : VOL_W;

  localparam int DIV_STEPS   = QUOT_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd3;

  localparam logic [QUOT_W-1:0] LIMIT_NEG = 32'h8000_0000;
  localparam logic [QUOT_W-1:0] LIMIT_POS = 32'h7FFF_FFFF;

  // word handed from the front to the back
  typedef struct packed {
    logic signed [DOT_W-1:0]  dot;
    logic signed [DATA_W-1:0] g_surf;
    logic signed [DATA_W-1:0] h_surf;
    logic [VOL_W-1:0]         vol_o;
    logic [VOL_W-1:0]         vol_n;
  } ffvu_item_t;

  // per-face context through the numerator stages
  typedef struct packed {
    logic [1:0]       neg;
    logic [VOL_W-1:0] vol_o;
    logic [VOL_W-1:0] vol_n;
  } ffvu_ctx_t;

  // per-side flags riding along the divider; sides: g own, g nbr, h own, h nbr
  typedef struct packed {
    logic [3:0] ovf;
    logic [3:0] neg;
    logic       zero_o;
    logic       zero_n;
  } ffvu_side_t;

endpackage
`default_nettype wire

[rtl/ffvu_front.sv]
// Front: accepts face words and forms the velocity-area dot product.
`default_nettype none
module ffvu_front (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  signed [ffvu_pkg::DATA_W-1:0] area_x_i,
  input  wire  signed [ffvu_pkg::DATA_W-1:0] area_y_i,
  input  wire  signed [ffvu_pkg::DATA_W-1:0] area_z_i,
  input  wire  signed [ffvu_pkg::DATA_W-1:0] g_surface_i,
  input  wire  signed [ffvu_pkg::DATA_W-1:0] h_surface_i,
  input  wire  [ffvu_pkg::VOL_W-1:0]    owner_volume_i,
  input  wire  [ffvu_pkg::VOL_W-1:0]    neighbour_volume_i,
  input  wire  signed [ffvu_pkg::DATA_W-1:0] vel_x_i,
  input  wire  signed [ffvu_pkg::DATA_W-1:0] vel_y_i,
  input  wire  signed [ffvu_pkg::DATA_W-1:0] vel_z_i,
  input  wire                           full_i,
  output logic                          push_o,
  output ffvu_pkg::ffvu_item_t          item_o
);
  import ffvu_pkg::*;

  logic                     v1_q, v2_q;
  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  logic signed [DATA_W-1:0] g1_q, h1_q;
  logic [VOL_W-1:0]         vo1_q, vn1_q;
  ffvu_item_t               item_q;
  logic                     en;
  logic signed [SUM_W-1:0]  sum;

  assign en         = !(v2_q && full_i);
  assign in_stall_o = v2_q && full_i;
  assign push_o     = v2_q && !full_i;
  assign item_o     = item_q;

  // exact sum, then floor shift
  assign sum = SUM_W'(px_q) + SUM_W'(py_q) + SUM_W'(pz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q         <= vel_x_i * area_x_i;
      py_q         <= vel_y_i * area_y_i;
      pz_q         <= vel_z_i * area_z_i;
      g1_q         <= g_surface_i;
      h1_q         <= h_surface_i;
      vo1_q        <= owner_volume_i;
      vn1_q        <= neighbour_volume_i;
      item_q.dot    <= sum[SUM_W-1:FRAC_BITS];
      item_q.g_surf <= g1_q;
      item_q.h_surf <= h1_q;
      item_q.vol_o  <= vo1_q;
      item_q.vol_n  <= vn1_q;
    end
  end

endmodule
`default_nettype wire

[rtl/ffvu_queue.sv]
// Short queue of words between the front and the back.
`default_nettype none
module ffvu_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  ffvu_pkg::ffvu_item_t item_i,
  input  wire                  pop_i,
  output ffvu_pkg::ffvu_item_t item_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import ffvu_pkg::*;

  ffvu_item_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule
`default_nettype wire

[rtl/ffvu_div.sv]
// Pipelined restoring divider: one quotient bit per stage.
`default_nettype none
module ffvu_div (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire  [ffvu_pkg::VOL_W-1:0]   rem_i,
  input  wire  [ffvu_pkg::QUOT_W-1:0]  lo_i,
  input  wire  [ffvu_pkg::VOL_W-1:0]   vol_i,
  output logic [ffvu_pkg::QUOT_W-1:0]  quot_o
);
  import ffvu_pkg::*;

  // low word shifts out dividend bits and takes quotient bits in
  logic [VOL_W-1:0]  rem_q [DIV_STEPS];
  logic [QUOT_W-1:0] lo_q  [DIV_STEPS];
  logic [VOL_W-1:0]  vol_q [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [VOL_W-1:0]  rem_in, vol_in;
    logic [QUOT_W-1:0] lo_in;
    logic [VOL_W:0]    trial;
    logic              take;

    if (s == 0) begin : g_first
      assign rem_in = rem_i;
      assign lo_in  = lo_i;
      assign vol_in = vol_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign lo_in  = lo_q[s-1];
      assign vol_in = vol_q[s-1];
    end

    assign trial = {rem_in, lo_in[QUOT_W-1]};
    assign take  = trial >= {1'b0, vol_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? VOL_W'(trial - {1'b0, vol_in}) : trial[VOL_W-1:0];
        lo_q[s]  <= {lo_in[QUOT_W-2:0], take};
        vol_q[s] <= vol_in;
      end
    end
  end

  assign quot_o = lo_q[DIV_STEPS-1];

endmodule
`default_nettype wire

[rtl/ffvu_back.sv]
// Back: flux numerators, four volume divisions, saturation and output register.
`default_nettype none
module ffvu_back (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  ffvu_pkg::ffvu_item_t           item_i,
  input  wire                            empty_i,
  output logic                           pop_o,
  input  wire  [ffvu_pkg::TS_W-1:0]      ts_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic signed [ffvu_pkg::DATA_W-1:0] g_owner_delta_o,
  output logic signed [ffvu_pkg::DATA_W-1:0] g_neighbour_delta_o,
  output logic signed [ffvu_pkg::DATA_W-1:0] h_owner_delta_o,
  output logic signed [ffvu_pkg::DATA_W-1:0] h_neighbour_delta_o,
  output logic                           owner_volume_zero_o,
  output logic                           neighbour_volume_zero_o,
  output logic                           saturated_o
);
  import ffvu_pkg::*;

  localparam int NSTG = 6;

  logic en;
  logic [NSTG-1:0]      sv_q;
  logic [DIV_STEPS-1:0] dv_q;
  logic                 out_valid_q;

  ffvu_ctx_t                 ctx_q [5];
  logic [DMAG_W-1:0]         dmag_q;
  logic [DATA_W-1:0]         smag_q [2];
  logic [PROD_W-1:0]         pp_lo_q [2];
  logic [DMAG_HI_W+DATA_W-1:0] pp_hi_q [2];
  logic [P1_W-1:0]           p1_q [2];
  logic [DATA_W+TS_W-1:0]    t0_q [2], t1_q [2];
  logic [P1_HI_W+TS_W-1:0]   t2_q [2];
  logic [NUM_W-1:0]          num_q [2];
  logic [VOL_W-1:0]          rem0_q [4], vol0_q [4];
  logic [QUOT_W-1:0]         lo0_q [4];
  logic [QUOT_W-1:0]         quot [4];
  ffvu_side_t                side5_q;
  ffvu_side_t                side_q [DIV_STEPS];

  logic [DOT_W-1:0]  dot_abs;
  logic              dot_neg;
  logic [DATA_W-1:0] smag_d [2];
  logic [1:0]        neg_d;
  logic [NUMF_W-1:0] numf [2];
  logic [VOL_W-1:0]  rem0_d [4], vol0_d [4];
  logic [QUOT_W-1:0] lo0_d [4];
  ffvu_side_t        side5_d;
  logic [DATA_W-1:0] res_d [4];
  logic              sat_d;

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && !empty_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q        <= '0;
      dv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      sv_q        <= {sv_q[NSTG-2:0], !empty_i};
      dv_q        <= {dv_q[DIV_STEPS-2:0], sv_q[NSTG-1]};
      out_valid_q <= dv_q[DIV_STEPS-1];
    end
  end

  // stage 0: magnitudes and signs
  always_comb begin
    logic signed [DATA_W-1:0] s;
    dot_neg = item_i.dot[DOT_W-1];
    dot_abs = dot_neg ? DOT_W'(-item_i.dot) : item_i.dot;
    for (int k = 0; k < 2; k++) begin
      s = (k == 0) ? item_i.g_surf : item_i.h_surf;
      smag_d[k] = s[DATA_W-1] ? DATA_W'(-s) : s;
      neg_d[k]  = dot_neg != s[DATA_W-1];
    end
  end

  // stage 4: sum partial products and drop the fraction
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      numf[k] = NUMF_W'(t0_q[k]) + (NUMF_W'(t1_q[k]) << DATA_W)
              + (NUMF_W'(t2_q[k]) << PROD_W);
    end
  end

  // stage 5: overflow check and divider setup per side
  always_comb begin
    logic [CMP_W-1:0] hi_x, vol_x;
    logic             neg_eff;
    side5_d.zero_o = ctx_q[4].vol_o == '0;
    side5_d.zero_n = ctx_q[4].vol_n == '0;
    for (int j = 0; j < 4; j++) begin
      vol0_d[j] = (j % 2 == 1) ? ctx_q[4].vol_n : ctx_q[4].vol_o;
      hi_x      = CMP_W'(num_q[j/2][NUM_W-1:QUOT_W]);
      vol_x     = CMP_W'(vol0_d[j]);
      side5_d.ovf[j] = hi_x >= vol_x;
      rem0_d[j] = hi_x[VOL_W-1:0];
      lo0_d[j]  = num_q[j/2][QUOT_W-1:0];
      // zero numerator takes the positive sign
      neg_eff = ctx_q[4].neg[j/2] && (num_q[j/2] != '0);
      side5_d.neg[j] = (j % 2 == 1) ? neg_eff : !neg_eff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q[0].neg   <= neg_d;
      ctx_q[0].vol_o <= item_i.vol_o;
      ctx_q[0].vol_n <= item_i.vol_n;
      for (int i = 1; i < 5; i++) ctx_q[i] <= ctx_q[i-1];
      dmag_q <= dot_abs[DMAG_W-1:0];
      for (int k = 0; k < 2; k++) begin
        smag_q[k]  <= smag_d[k];
        pp_lo_q[k] <= dmag_q[DATA_W-1:0] * smag_q[k];
        pp_hi_q[k] <= dmag_q[DMAG_W-1:DATA_W] * smag_q[k];
        p1_q[k]    <= P1_W'(pp_lo_q[k]) + (P1_W'(pp_hi_q[k]) << DATA_W);
        t0_q[k]    <= p1_q[k][DATA_W-1:0] * ts_i;
        t1_q[k]    <= p1_q[k][PROD_W-1:DATA_W] * ts_i;
        t2_q[k]    <= p1_q[k][P1_W-1:PROD_W] * ts_i;
        num_q[k]   <= numf[k][NUMF_W-1:FRAC_BITS];
      end
      for (int j = 0; j < 4; j++) begin
        rem0_q[j] <= rem0_d[j];
        lo0_q[j]  <= lo0_d[j];
        vol0_q[j] <= vol0_d[j];
      end
      side5_q   <= side5_d;
      side_q[0] <= side5_q;
      for (int i = 1; i < DIV_STEPS; i++) side_q[i] <= side_q[i-1];
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_div
    ffvu_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rem0_q[j]),
      .lo_i   (lo0_q[j]),
      .vol_i  (vol0_q[j]),
      .quot_o (quot[j])
    );
  end

  // saturation, sign and zero-volume forcing
  always_comb begin
    ffvu_side_t        sd;
    logic [QUOT_W-1:0] limit, mag;
    logic              zero, clip;
    sd    = side_q[DIV_STEPS-1];
    sat_d = 1'b0;
    for (int j = 0; j < 4; j++) begin
      zero  = (j % 2 == 1) ? sd.zero_n : sd.zero_o;
      limit = sd.neg[j] ? LIMIT_NEG : LIMIT_POS;
      clip  = sd.ovf[j] || (quot[j] > limit);
      mag   = clip ? limit : quot[j];
      if (zero) begin
        res_d[j] = '0;
      end else begin
        res_d[j] = sd.neg[j] ? DATA_W'(-mag) : mag;
        sat_d    = sat_d || clip;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_owner_delta_o         <= res_d[0];
      g_neighbour_delta_o     <= res_d[1];
      h_owner_delta_o         <= res_d[2];
      h_neighbour_delta_o     <= res_d[3];
      owner_volume_zero_o     <= side_q[DIV_STEPS-1].zero_o;
      neighbour_volume_zero_o <= side_q[DIV_STEPS-1].zero_n;
      saturated_o             <= sat_d;
    end
  end

endmodule
`default_nettype wire

[rtl/face_flux_volume_update_unit.sv]
// Top level of the face flux volume update unit.
// Takes one face word per cycle while in_stall_o is low and returns one result word per face, in order.
// The path runs through 2 front stages, the queue, 6 numerator stages, 32
// divider stages and the output register. The four volume divisions are
// pipelined restoring dividers that produce one quotient bit per stage, which
// sets the latency; throughput stays at one face per cycle while the output is
// not stalled. A stall on the output while a result is valid freezes the back;
// the front keeps filling the queue and stalls its input only once the queue
// is full. Configuration writes are always ready and belong to idle periods.
`default_nettype none
module face_flux_volume_update_unit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [ffvu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [ffvu_pkg::DATA_W-1:0]        cfg_data_i,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  signed [ffvu_pkg::DATA_W-1:0] area_x_i,
  input  wire  signed [ffvu_pkg::DATA_W-1:0] area_y_i,
  input  wire  signed [ffvu_pkg::DATA_W-1:0] area_z_i,
  input  wire  signed [ffvu_pkg::DATA_W-1:0] g_surface_i,
  input  wire  signed [ffvu_pkg::DATA_W-1:0] h_surface_i,
  input  wire  [ffvu_pkg::VOL_W-1:0]         owner_volume_i,
  input  wire  [ffvu_pkg::VOL_W-1:0]         neighbour_volume_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic signed [ffvu_pkg::DATA_W-1:0] g_owner_delta_o,
  output logic signed [ffvu_pkg::DATA_W-1:0] g_neighbour_delta_o,
  output logic signed [ffvu_pkg::DATA_W-1:0] h_owner_delta_o,
  output logic signed [ffvu_pkg::DATA_W-1:0] h_neighbour_delta_o,
  output logic                               owner_volume_zero_o,
  output logic                               neighbour_volume_zero_o,
  output logic                               saturated_o
);
  import ffvu_pkg::*;

  logic signed [DATA_W-1:0] vel_x_q, vel_y_q, vel_z_q;
  logic [TS_W-1:0]          ts_q;
  logic                     q_push, q_pop, q_full, q_empty;
  ffvu_item_t               q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_x_q <= '0;
      vel_y_q <= '0;
      vel_z_q <= '0;
      ts_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_VEL_X:     vel_x_q <= cfg_data_i;
        CFG_VEL_Y:     vel_y_q <= cfg_data_i;
        CFG_VEL_Z:     vel_z_q <= cfg_data_i;
        CFG_TIME_STEP: ts_q    <= cfg_data_i[TS_W-1:0];
        default: ;
      endcase
    end
  end

  ffvu_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .area_x_i           (area_x_i),
    .area_y_i           (area_y_i),
    .area_z_i           (area_z_i),
    .g_surface_i        (g_surface_i),
    .h_surface_i        (h_surface_i),
    .owner_volume_i     (owner_volume_i),
    .neighbour_volume_i (neighbour_volume_i),
    .vel_x_i            (vel_x_q),
    .vel_y_i            (vel_y_q),
    .vel_z_i            (vel_z_q),
    .full_i             (q_full),
    .push_o             (q_push),
    .item_o             (q_in)
  );

  ffvu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ffvu_back u_back (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .item_i                  (q_out),
    .empty_i                 (q_empty),
    .pop_o                   (q_pop),
    .ts_i                    (ts_q),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .g_owner_delta_o         (g_owner_delta_o),
    .g_neighbour_delta_o     (g_neighbour_delta_o),
    .h_owner_delta_o         (h_owner_delta_o),
    .h_neighbour_delta_o     (h_neighbour_delta_o),
    .owner_volume_zero_o     (owner_volume_zero_o),
    .neighbour_volume_zero_o (neighbour_volume_zero_o),
    .saturated_o             (saturated_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full && !q_pop)) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty)) else $error("queue pop while empty");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_full) else $error("input stalled with room in queue");

  a_zero_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && owner_volume_zero_o) |->
      (g_owner_delta_o == '0 && h_owner_delta_o == '0))
    else $error("zero owner volume gave nonzero delta");

endmodule
`default_nettype wire
